// File: sv/lstb_pkg.sv
// shared types and constants for the token bucket link shaper
package lstb_pkg;

    localparam int QueueDepthDefault = 32;
    localparam int MaxFrameDefault   = 1518;
    localparam int TokensPerByte     = 1000;

    typedef enum logic [1:0] {
        CMD_OFFER = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ADMIT   = 3'd0,
        KIND_LOST    = 3'd1,
        KIND_DROP    = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_TICK    = 3'd4,
        KIND_COUNTER = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REG_LOSS   = 3'd0,
        REG_DELAY  = 3'd1,
        REG_QLIMIT = 3'd2,
        REG_BUCKET = 3'd3,
        REG_RATE   = 3'd4,
        REG_SILENT = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        CNT_STALL_P = 4'd0,
        CNT_STALL_B = 4'd1,
        CNT_DROP_P  = 4'd2,
        CNT_DROP_B  = 4'd3,
        CNT_LOSS_P  = 4'd4,
        CNT_LOSS_B  = 4'd5,
        CNT_ENQ_P   = 4'd6,
        CNT_ENQ_B   = 4'd7,
        CNT_DEQ_P   = 4'd8,
        CNT_DEQ_B   = 4'd9,
        CNT_STO_P   = 4'd10,
        CNT_STO_B   = 4'd11
    } cnt_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_POP,
        ST_DONE,
        ST_EMIT,
        ST_ADD,
        ST_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic offer;
        logic read;
        logic add_tokens;
        logic silent_arm;
        logic stall;
        logic pop_take;
        logic tick_done;
        logic emit_pop;
        logic out_load;
    } lstb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fifo_empty;
        logic silent_mode;
        logic silent_due;
        logic head_young;
        logic shaping;
        logic tokens_ok;
        logic out_busy;
    } lstb_stat_t;

endpackage

// File: sv/lstb_ctrl.sv
// controller state machine for the token bucket link shaper
module lstb_ctrl import lstb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  cmd_t       cmd,
    input  lstb_stat_t stat,
    output logic       busy,
    output lstb_cmd_t  ctl
);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.capture = 1'b1;
                    cmd_next    = cmd;
                    if (cmd == CMD_TICK)
                        state_next = ST_FILL;
                    else if (cmd != CMD_NONE)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // one-result commands: evaluate and load output
                if (!stat.out_busy)
                begin
                    ctl.offer    = (cmd_reg == CMD_OFFER);
                    ctl.read     = (cmd_reg == CMD_READ);
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (stat.silent_mode)
                begin
                    if (stat.silent_due && !stat.fifo_empty)
                    begin
                        ctl.silent_arm = 1'b1;
                        state_next     = ST_POP;
                    end
                    else
                        state_next = ST_DONE;
                end
                else
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // fill product is registered by now, add and clamp
                ctl.add_tokens = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.fifo_empty || stat.head_young)
                    state_next = ST_DONE;
                else if (stat.shaping && !stat.tokens_ok)
                begin
                    ctl.stall  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.pop_take = stat.shaping;
                    state_next   = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!stat.out_busy)
                begin
                    ctl.emit_pop = 1'b1;
                    ctl.out_load = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // new head descriptor is read in this cycle
                if (stat.silent_mode)
                    state_next = stat.fifo_empty ? ST_DONE : ST_POP;
                else
                    state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.tick_done = 1'b1;
                    ctl.out_load  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: sv/lstb_dp.sv
// datapath: registers, descriptor fifo, token bucket and counters
module lstb_dp import lstb_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int MAX_FRAME   = MaxFrameDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  lstb_cmd_t   ctl,
    output lstb_stat_t  stat,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic [13:0] packet_length,
    input  logic [13:0] random_sample,
    input  logic [47:0] current_time,
    input  logic [19:0] elapsed,
    input  logic [3:0]  counter_select,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  kind,
    output logic [13:0] out_length,
    output logic [47:0] counter_value,
    output logic        last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(QUEUE_DEPTH - 1);

    logic [13:0] loss_reg;
    logic [31:0] delay_reg, qlimit_reg, silent_per_reg;
    logic [47:0] bucket_reg;
    logic [23:0] rate_reg;

    logic [13:0] len_reg, sample_reg;
    logic [47:0] now_reg;
    logic [19:0] elapsed_reg;
    logic [3:0]  sel_reg;

    logic [47:0] tokens_reg, silent_start_reg;
    logic [AW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic [47:0] stat_reg [12];

    logic [13:0] mem_len [QUEUE_DEPTH];
    logic [47:0] mem_arr [QUEUE_DEPTH];
    logic [13:0] head_len_reg;
    logic [47:0] head_arr_reg;

    logic [43:0] fill_prod_reg;
    logic [23:0] need;

    logic        ov_reg;
    logic [2:0]  kind_reg;
    logic [13:0] olen_reg;
    logic [47:0] oval_reg;
    logic        last_reg;

    // offer decisions
    logic is_lost, is_full, is_over, admit;
    logic [47:0] age;
    logic [48:0] tok_sum;
    logic [47:0] tok_clamped;
    logic [AW-1:0] head_inc, tail_inc;

    assign is_lost = (loss_reg != 14'd0) && (sample_reg <= loss_reg);
    assign is_over = (rate_reg != 24'd0) &&
                     !((stat_reg[CNT_STO_B] + 48'(MAX_FRAME)) < {16'd0, qlimit_reg});
    assign is_full = (count_reg >= CW'(QUEUE_DEPTH));
    assign admit   = !is_lost && !is_over && !is_full;
    assign age     = now_reg - head_arr_reg;
    assign need    = 24'(head_len_reg) * 24'(TokensPerByte);
    assign tok_sum = {1'b0, tokens_reg} + {5'd0, fill_prod_reg};
    assign tok_clamped = (tok_sum > {1'b0, bucket_reg}) ? bucket_reg : tok_sum[47:0];
    assign head_inc = (head_reg == LastAddr) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LastAddr) ? '0 : tail_reg + 1'b1;

    assign stat.fifo_empty  = (count_reg == '0);
    assign stat.silent_mode = (silent_per_reg != 32'd0);
    assign stat.silent_due  = ({1'b0, now_reg} >=
                               ({1'b0, silent_start_reg} + {17'd0, silent_per_reg}));
    assign stat.head_young  = (delay_reg != 32'd0) && (age < {16'd0, delay_reg});
    assign stat.shaping     = (rate_reg != 24'd0);
    assign stat.tokens_ok   = (tokens_reg > {24'd0, need});
    assign stat.out_busy    = ov_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_reg       <= '0;
            delay_reg      <= '0;
            qlimit_reg     <= '0;
            bucket_reg     <= '0;
            rate_reg       <= '0;
            silent_per_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOSS:   loss_reg       <= cfg_data[13:0];
                REG_DELAY:  delay_reg      <= cfg_data[31:0];
                REG_QLIMIT: qlimit_reg     <= cfg_data[31:0];
                REG_BUCKET: bucket_reg     <= cfg_data;
                REG_RATE:   rate_reg       <= cfg_data[23:0];
                REG_SILENT: silent_per_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // item capture, fill product, head descriptor read and fifo write
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            len_reg     <= packet_length;
            sample_reg  <= random_sample;
            now_reg     <= current_time;
            elapsed_reg <= elapsed;
            sel_reg     <= counter_select;
        end
        fill_prod_reg <= 44'(rate_reg) * 44'(elapsed_reg);
        head_len_reg  <= mem_len[head_reg];
        head_arr_reg  <= mem_arr[head_reg];
        if (ctl.offer && admit)
        begin
            mem_len[tail_reg] <= len_reg;
            mem_arr[tail_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_reg       <= '0;
            silent_start_reg <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            for (int i = 0; i < 12; i++)
                stat_reg[i] <= '0;
        end
        else
        begin
            if (ctl.add_tokens)
                tokens_reg <= tok_clamped;
            else if (ctl.pop_take)
                tokens_reg <= tokens_reg - {24'd0, need};
            if (ctl.silent_arm)
                silent_start_reg <= now_reg;
            if (ctl.offer)
            begin
                if (is_lost)
                begin
                    stat_reg[CNT_LOSS_P] <= stat_reg[CNT_LOSS_P] + 48'd1;
                    stat_reg[CNT_LOSS_B] <= stat_reg[CNT_LOSS_B] + {34'd0, len_reg};
                end
                else if (!admit)
                begin
                    stat_reg[CNT_DROP_P] <= stat_reg[CNT_DROP_P] + 48'd1;
                    stat_reg[CNT_DROP_B] <= stat_reg[CNT_DROP_B] + {34'd0, len_reg};
                end
                else
                begin
                    tail_reg  <= tail_inc;
                    count_reg <= count_reg + 1'b1;
                    stat_reg[CNT_ENQ_P] <= stat_reg[CNT_ENQ_P] + 48'd1;
                    stat_reg[CNT_ENQ_B] <= stat_reg[CNT_ENQ_B] + {34'd0, len_reg};
                    stat_reg[CNT_STO_P] <= stat_reg[CNT_STO_P] + 48'd1;
                    stat_reg[CNT_STO_B] <= stat_reg[CNT_STO_B] + {34'd0, len_reg};
                end
            end
            if (ctl.stall)
            begin
                stat_reg[CNT_STALL_P] <= stat_reg[CNT_STALL_P] + 48'd1;
                stat_reg[CNT_STALL_B] <= stat_reg[CNT_STALL_B] + {34'd0, head_len_reg};
            end
            if (ctl.emit_pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
                stat_reg[CNT_DEQ_P] <= stat_reg[CNT_DEQ_P] + 48'd1;
                stat_reg[CNT_DEQ_B] <= stat_reg[CNT_DEQ_B] + {34'd0, head_len_reg};
                stat_reg[CNT_STO_P] <= stat_reg[CNT_STO_P] - 48'd1;
                stat_reg[CNT_STO_B] <= stat_reg[CNT_STO_B] - {34'd0, head_len_reg};
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (ctl.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            if (ctl.offer)
            begin
                kind_reg <= is_lost ? KIND_LOST : (admit ? KIND_ADMIT : KIND_DROP);
                olen_reg <= len_reg;
                oval_reg <= '0;
                last_reg <= 1'b1;
            end
            else if (ctl.read)
            begin
                kind_reg <= KIND_COUNTER;
                olen_reg <= '0;
                oval_reg <= (sel_reg < 4'd12) ? stat_reg[sel_reg] : 48'd0;
                last_reg <= 1'b1;
            end
            else if (ctl.emit_pop)
            begin
                kind_reg <= KIND_RELEASE;
                olen_reg <= head_len_reg;
                oval_reg <= '0;
                last_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= KIND_TICK;
                olen_reg <= '0;
                oval_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid     = ov_reg;
    assign kind          = kind_reg;
    assign out_length    = olen_reg;
    assign counter_value = oval_reg;
    assign last          = last_reg;

endmodule

// File: sv/link_shaper_token_bucket_unit.sv
// top level of the token bucket link shaper, one link direction
// An offer or a counter read is captured, then decided and loaded into the result
// register, and gives one transfer. A tick in normal mode is captured, waits for
// the registered fill product, adds and clamps tokens, checks the head and loads
// the done result; each released packet adds a pop, a wait for the registered fifo
// head read and a check of the next head. A tick in silent mode adds a pop and a
// head read per flushed packet. A stalled output register delays every result
// load. The next item is taken once the last result is in the output register.
// Configuration is to be written only while idle; the block does not enforce this.
module link_shaper_token_bucket_unit import lstb_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int MAX_FRAME   = MaxFrameDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [13:0] packet_length,
    input  logic [13:0] random_sample,
    input  logic [47:0] current_time,
    input  logic [19:0] elapsed,
    input  logic [3:0]  counter_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [13:0] out_length,
    output logic [47:0] counter_value,
    output logic        last
);

    lstb_cmd_t  ctl;
    lstb_stat_t stat;
    logic       busy;
    logic       in_fire;

    // take a new item only while the controller is idle
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    lstb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .cmd     (cmd_t'(command)),
        .stat    (stat),
        .busy    (busy),
        .ctl     (ctl)
    );

    lstb_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_FRAME   (MAX_FRAME)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .packet_length  (packet_length),
        .random_sample  (random_sample),
        .current_time   (current_time),
        .elapsed        (elapsed),
        .counter_select (counter_select),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .kind           (kind),
        .out_length     (out_length),
        .counter_value  (counter_value),
        .last           (last)
    );

    // a pending result stays valid until it is taken
    a_no_load_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending result lost");

    // the controller only loads output when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !(out_valid && !out_ready))
        else $error("output overwritten");

    // an accepted item other than CMD_NONE makes the controller busy
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy || !$past(command != CMD_NONE))
        else $error("accept without work");

endmodule

// File: test/tb_top.sv
// testbench for the token bucket link shaper: predictor, driver, monitor and checker
`timescale 1ns / 100ps

module tb_top import lstb_pkg::*;;

    localparam int DEPTH = QueueDepthDefault;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        cmd_t        command;
        logic [13:0] packet_length;
        logic [13:0] random_sample;
        logic [47:0] current_time;
        logic [19:0] elapsed;
        logic [3:0]  counter_select;
    } shaper_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [13:0] out_length;
        logic [47:0] counter_value;
        logic        last;
    } shaper_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [13:0] packet_length;
    logic [13:0] random_sample;
    logic [47:0] current_time;
    logic [19:0] elapsed;
    logic [3:0]  counter_select;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [13:0] out_length;
    logic [47:0] counter_value;
    logic        last;

    link_shaper_token_bucket_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .packet_length(packet_length),
        .random_sample(random_sample), .current_time(current_time),
        .elapsed(elapsed), .counter_select(counter_select),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_length(out_length),
        .counter_value(counter_value), .last(last)
    );

    // shadow of the shaper configuration
    logic [13:0] sh_loss;
    logic [31:0] sh_delay;
    logic [31:0] sh_qlimit;
    logic [47:0] sh_bucket;
    logic [23:0] sh_rate;
    logic [31:0] sh_silent;

    // shadow of the shaper state
    logic [47:0] sh_tokens;
    logic [47:0] sh_silent_start;
    logic [13:0] sh_len_q [DEPTH];
    logic [47:0] sh_arr_q [DEPTH];
    int          sh_head;
    int          sh_tail;
    int          sh_count;
    logic [47:0] sh_stats [12];

    shaper_item_t   pending_items [$];
    shaper_result_t expected_results [$];

    int mismatches;
    int results_seen;
    int releases_seen;
    int items_sent;

    // idling knobs: percent chance of idling per cycle
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void bump_stat(int base, logic [13:0] len);
        sh_stats[base]     = (sh_stats[base] + 48'd1) & MASK48;
        sh_stats[base + 1] = (sh_stats[base + 1] + 48'(len)) & MASK48;
    endfunction

    function automatic void push_result(kind_t k, logic [13:0] len, logic [47:0] val,
                                        logic lst);
        shaper_result_t r;
        r.kind = k;
        r.out_length = len;
        r.counter_value = val;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void pop_head_packet();
        logic [13:0] len;
        len = sh_len_q[sh_head];
        sh_head = (sh_head + 1 >= DEPTH) ? 0 : sh_head + 1;
        sh_count--;
        bump_stat(CNT_DEQ_P, len);
        sh_stats[CNT_STO_P] = (sh_stats[CNT_STO_P] - 48'd1) & MASK48;
        sh_stats[CNT_STO_B] = (sh_stats[CNT_STO_B] - 48'(len)) & MASK48;
        push_result(KIND_RELEASE, len, 48'd0, 1'b0);
    endfunction

    // work out the transfers one accepted item causes
    function automatic void predict_shaper(shaper_item_t it);
        logic [63:0] tok;
        logic [63:0] need;
        logic [47:0] age;
        logic [63:0] stored;
        unique case (it.command)
            CMD_OFFER:
            begin
                stored = 64'(sh_stats[CNT_STO_B]) + 64'(MaxFrameDefault);
                if (sh_loss != 0 && it.random_sample <= sh_loss)
                begin
                    bump_stat(CNT_LOSS_P, it.packet_length);
                    push_result(KIND_LOST, it.packet_length, 48'd0, 1'b1);
                end
                else if ((sh_rate != 0 && !(stored < 64'(sh_qlimit)))
                         || sh_count >= DEPTH)
                begin
                    bump_stat(CNT_DROP_P, it.packet_length);
                    push_result(KIND_DROP, it.packet_length, 48'd0, 1'b1);
                end
                else
                begin
                    sh_len_q[sh_tail] = it.packet_length;
                    sh_arr_q[sh_tail] = it.current_time;
                    sh_tail = (sh_tail + 1 >= DEPTH) ? 0 : sh_tail + 1;
                    sh_count++;
                    bump_stat(CNT_ENQ_P, it.packet_length);
                    bump_stat(CNT_STO_P, it.packet_length);
                    push_result(KIND_ADMIT, it.packet_length, 48'd0, 1'b1);
                end
            end
            CMD_TICK:
            begin
                if (sh_silent != 0)
                begin
                    if (64'(it.current_time) >= 64'(sh_silent_start) + 64'(sh_silent)
                        && sh_count != 0)
                    begin
                        sh_silent_start = it.current_time;
                        while (sh_count != 0) pop_head_packet();
                    end
                end
                else
                begin
                    // sum taken wide so the clamp sees the full value
                    tok = 64'(sh_tokens) + 64'(sh_rate) * 64'(it.elapsed);
                    if (tok > 64'(sh_bucket)) tok = 64'(sh_bucket);
                    sh_tokens = tok[47:0];
                    while (sh_count != 0)
                    begin
                        age = (it.current_time - sh_arr_q[sh_head]) & MASK48;
                        need = 64'(sh_len_q[sh_head]) * 64'(TokensPerByte);
                        if (sh_delay != 0 && age < 48'(sh_delay)) break;
                        if (sh_rate != 0)
                        begin
                            if (64'(sh_tokens) > need)
                            begin
                                sh_tokens = sh_tokens - need[47:0];
                            end
                            else
                            begin
                                bump_stat(CNT_STALL_P, sh_len_q[sh_head]);
                                break;
                            end
                        end
                        pop_head_packet();
                    end
                end
                push_result(KIND_TICK, 14'd0, 48'd0, 1'b1);
            end
            CMD_READ:
                push_result(KIND_COUNTER, 14'd0,
                            (it.counter_select < 12) ? sh_stats[it.counter_select] : 48'd0,
                            1'b1);
            default:
            begin
                // unused command gives no transfer
            end
        endcase
    endfunction

    // driver: offers the head of the pending queue, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_shaper(pending_items.pop_front());
                items_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    command        <= pending_items[0].command;
                    packet_length  <= pending_items[0].packet_length;
                    random_sample  <= pending_items[0].random_sample;
                    current_time   <= pending_items[0].current_time;
                    elapsed        <= pending_items[0].elapsed;
                    counter_select <= pending_items[0].counter_select;
                    in_valid       <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off counted in its own process, random receiver stalls after it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        shaper_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (kind == KIND_RELEASE) releases_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer kind %0d len %0d val %0d last %0d",
                             kind, out_length, counter_value, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind || out_length !== want.out_length ||
                    counter_value !== want.counter_value || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %0d len %0d val %0d last %0d, ",
                                  "got kind %0d len %0d val %0d last %0d"},
                                 want.kind, want.out_length, want.counter_value,
                                 want.last, kind, out_length, counter_value, last);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [47:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        unique case (idx)
            REG_LOSS:   sh_loss   = value[13:0];
            REG_DELAY:  sh_delay  = value[31:0];
            REG_QLIMIT: sh_qlimit = value[31:0];
            REG_BUCKET: sh_bucket = value;
            REG_RATE:   sh_rate   = value[23:0];
            REG_SILENT: sh_silent = value[31:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_profile(logic [13:0] loss, logic [31:0] dly, logic [31:0] qlim,
                               logic [47:0] bkt, logic [23:0] rate, logic [31:0] sil);
        write_reg(REG_LOSS, 48'(loss));
        write_reg(REG_DELAY, 48'(dly));
        write_reg(REG_QLIMIT, 48'(qlim));
        write_reg(REG_BUCKET, bkt);
        write_reg(REG_RATE, 48'(rate));
        write_reg(REG_SILENT, 48'(sil));
    endtask

    // wait until everything queued has gone through, plus a tail for the block
    task automatic drain_all();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_item(cmd_t c, logic [13:0] len, logic [13:0] smp, logic [47:0] t,
                              logic [19:0] el, logic [3:0] sel);
        shaper_item_t it;
        it.command = c;
        it.packet_length = len;
        it.random_sample = smp;
        it.current_time = t;
        it.elapsed = el;
        it.counter_select = sel;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(logic [47:0] t);
        int r;
        r = $urandom_range(99);
        if (r < 55)
            queue_item(CMD_OFFER, ($urandom_range(9) == 0) ? 14'($urandom) :
                       14'($urandom_range(64, 1518)), 14'($urandom_range(9999)),
                       t, 20'($urandom), 4'($urandom));
        else if (r < 85)
            queue_item(CMD_TICK, 14'($urandom), 14'($urandom), t,
                       ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2000)),
                       4'($urandom));
        else if (r < 97)
            queue_item(CMD_READ, 14'($urandom), 14'($urandom), t, 20'($urandom),
                       4'($urandom));
        else
            queue_item(CMD_NONE, 14'($urandom), 14'($urandom), t, 20'($urandom),
                       4'($urandom));
    endtask

    // a stretch of random traffic with time moving forward, now and then backward
    task automatic run_random(int n, inout logic [47:0] t);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0) t = t - 48'($urandom_range(500));
            else t = t + 48'($urandom_range(300));
            queue_random(t);
        end
        drain_all();
    endtask

    initial
    begin
        logic [47:0] now;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        command = CMD_OFFER;
        packet_length = '0;
        random_sample = '0;
        current_time = '0;
        elapsed = '0;
        counter_select = '0;
        mismatches = 0;
        results_seen = 0;
        releases_seen = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        sh_loss = 0; sh_delay = 0; sh_qlimit = 0; sh_bucket = 0; sh_rate = 0; sh_silent = 0;
        sh_tokens = 0; sh_silent_start = 0; sh_head = 0; sh_tail = 0; sh_count = 0;
        for (int i = 0; i < 12; i++) sh_stats[i] = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain pass-through, extremes of lengths, full fifo, all counters
        queue_item(CMD_OFFER, 14'd0, 14'd0, 48'd0, 20'd0, 4'd0);
        queue_item(CMD_OFFER, 14'h3FFF, 14'h3FFF, MASK48, 20'hFFFFF, 4'hF);
        queue_item(CMD_NONE, 14'd5, 14'd5, 48'd5, 20'd5, 4'd5);
        queue_item(CMD_TICK, 14'd0, 14'd0, 48'd10, 20'd0, 4'd0);
        for (int i = 0; i < 34; i++)
            queue_item(CMD_OFFER, 14'(i + 60), 14'd0, 48'(i), 20'd0, 4'd0);
        queue_item(CMD_READ, 14'd0, 14'd0, 48'd0, 20'd0, 4'd2);
        queue_item(CMD_TICK, 14'd0, 14'd0, 48'd50, 20'hFFFFF, 4'd0);
        for (int s = 0; s < 16; s++)
            queue_item(CMD_READ, 14'd0, 14'd0, 48'd0, 20'd0, 4'(s));
        drain_all();

        // loss at the top end, delay with time running backwards
        set_profile(14'd10000, 32'd100, 32'hFFFF_FFFF, 48'd0, 24'd0, 32'd0);
        queue_item(CMD_OFFER, 14'd100, 14'd9999, 48'd1000, 20'd0, 4'd0);
        drain_all();
        set_profile(14'd5000, 32'd100, 32'hFFFF_FFFF, 48'd0, 24'd0, 32'd0);
        queue_item(CMD_OFFER, 14'd100, 14'd5000, 48'd1000, 20'd0, 4'd0);
        queue_item(CMD_OFFER, 14'd200, 14'd5001, 48'd1000, 20'd0, 4'd0);
        queue_item(CMD_TICK, 14'd0, 14'd0, 48'd1050, 20'd1, 4'd0);
        queue_item(CMD_TICK, 14'd0, 14'd0, 48'd500, 20'd1, 4'd0);
        queue_item(CMD_READ, 14'd0, 14'd0, 48'd0, 20'd0, CNT_LOSS_B);
        drain_all();

        now = 48'd2000;
        // shaping with stalls, random traffic and no idling
        set_profile(14'd0, 32'd0, 32'd40000, 48'd3_000_000, 24'd1000, 32'd0);
        run_random(60, now);

        // receiver stalls; long hold-off fills the block and stalls the input
        recv_stall_pct = 53;
        set_profile(14'd2000, 32'd20, 32'd0, MASK48, 24'hFFFFFF, 32'd0);
        hold_off_cycles = 400;
        run_random(50, now);

        // silent flush mode, sender idling
        recv_stall_pct = 0;
        send_idle_pct = 53;
        set_profile(14'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0, 24'd0, 32'd400);
        queue_item(CMD_TICK, 14'd0, 14'd0, now, 20'd0, 4'd0);
        run_random(50, now);

        // both sides idle, shaping off, no delay
        recv_stall_pct = 15;
        send_idle_pct = 15;
        set_profile(14'd1, 32'd0, 32'd0, 48'd0, 24'd0, 32'd0);
        run_random(45, now);
        queue_item(CMD_TICK, 14'd0, 14'd0, now, 20'd0, 4'd0);
        for (int s = 0; s < 12; s++)
            queue_item(CMD_READ, 14'd0, 14'd0, 48'd0, 20'd0, 4'(s));
        drain_all();

        $display("covered %0d items, %0d transfers checked, %0d packet releases",
                 items_sent, results_seen, releases_seen);
        $display("modes: plain, loss, delay, shaping with stall, silent flush, full fifo");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
sv/lstb_pkg.sv
sv/lstb_ctrl.sv
sv/lstb_dp.sv
sv/link_shaper_token_bucket_unit.sv
test/tb_top.sv
